[hdl/acs_pkg.sv]
// acs_pkg: shared types, codes and constants of the accumulator step core.
// Used by acs_store and accumulator_cpu_step_top; no dependencies.
package acs_pkg;

  localparam int unsigned PROG_DEPTH = 256;
  localparam int unsigned PROG_AW    = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
  localparam logic [7:0]  PROG_RESET0 = 8'h07;  // HLT at address zero after reset

  // 8-bit address to store index (address mod depth) as a constant table
  function automatic logic [PROG_AW-1:0] prog_index(logic [7:0] addr);
    logic [PROG_AW-1:0] idx;
    int unsigned        wrap;
    idx  = '0;
    wrap = 0;
    for (int i = 0; i < 256; i++) begin
      if (addr == 8'(i)) idx = PROG_AW'(wrap);
      wrap = (wrap == PROG_DEPTH - 1) ? 0 : wrap + 1;
    end
    return idx;
  endfunction

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_EXECUTED = 3'd0,
    ST_WAIT     = 3'd1,
    ST_HALTED   = 3'd2,
    ST_FAULTED  = 3'd3,
    ST_LOADED   = 3'd4
  } status_e;

  // instruction low nibble
  typedef enum logic [3:0] {
    I_NOP   = 4'h0,
    I_SWP   = 4'h1,
    I_SAV   = 4'h2,
    I_ADD   = 4'h3,
    I_SUB   = 4'h4,
    I_NEG   = 4'h5,
    I_JRO   = 4'h6,
    I_HLT   = 4'h7,
    I_MOVR  = 4'h8,
    I_MOVI  = 4'h9,
    I_ADDI  = 4'hA,
    I_SUBI  = 4'hB,
    I_JCC   = 4'hC,
    I_JROI  = 4'hD,
    I_BADE  = 4'hE,
    I_BADF  = 4'hF
  } insn_e;

  // jump condition in the high nibble
  localparam logic [3:0] JC_JMP = 4'h0;
  localparam logic [3:0] JC_JEZ = 4'h1;
  localparam logic [3:0] JC_JNZ = 4'h2;
  localparam logic [3:0] JC_JGZ = 4'h3;
  localparam logic [3:0] JC_JLZ = 4'h4;

  // register codes
  localparam logic [7:0] RC_ACC  = 8'd1;
  localparam logic [7:0] RC_NIL  = 8'd2;
  localparam logic [7:0] RC_PORT = 8'd8;   // this and above

  typedef enum logic [1:0] {
    K_BAD  = 2'd0,
    K_ACC  = 2'd1,
    K_NIL  = 2'd2,
    K_PORT = 2'd3
  } kind_e;

  function automatic kind_e reg_kind(logic [7:0] code);
    kind_e k;
    if (code >= RC_PORT)     k = K_PORT;
    else if (code == RC_ACC) k = K_ACC;
    else if (code == RC_NIL) k = K_NIL;
    else                     k = K_BAD;
    return k;
  endfunction

  typedef struct packed {
    op_e        opcode;
    logic [7:0] load_address;
    logic [7:0] load_byte;
    logic [7:0] port_byte;
    logic       port_byte_valid;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic              port_consumed;
    logic              out_valid;
    logic [7:0]        out_byte;
    logic signed [7:0] accumulator;
    logic [7:0]        next_pc;
  } out_item_t;

  // single port store request
  typedef struct packed {
    logic               en;
    logic               we;
    logic [PROG_AW-1:0] addr;
    logic [7:0]         wdata;
  } st_req_t;

endpackage

[hdl/acs_store.sv]
// acs_store: single-port program store, registered read.
// Per-entry valid bits give the reset image without a clearing pass. Uses acs_pkg.
module acs_store (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  acs_pkg::st_req_t req_i,
  output logic [7:0]      rdata_o
);

  logic [7:0]                    mem [acs_pkg::PROG_DEPTH];
  logic [acs_pkg::PROG_DEPTH-1:0] vld_q;
  logic [7:0]                    rdata_q;
  logic                          rd_vld_q;
  logic                          rd_zero_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem[req_i.addr] <= req_i.wdata;
      end else begin
        rdata_q <= mem[req_i.addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_zero_q <= 1'b0;
    end else if (req_i.en) begin
      if (req_i.we) begin
        vld_q[req_i.addr] <= 1'b1;
      end else begin
        rd_vld_q  <= vld_q[req_i.addr];
        rd_zero_q <= (req_i.addr == '0);
      end
    end
  end

  // never-written entries read as the reset image
  assign rdata_o = rd_vld_q  ? rdata_q :
                   rd_zero_q ? acs_pkg::PROG_RESET0 : 8'h00;

endmodule

[hdl/accumulator_cpu_step_top.sv]
// accumulator_cpu_step_top: 8-bit accumulator processor, one instruction per item.
// Depends on acs_pkg and acs_store.
//
// Usage
//   Input channel in_valid_i / in_stall_o / in_item_i: opcode OP_LOAD writes
//   load_byte at load_address; OP_STEP executes one instruction, with
//   port_byte / port_byte_valid offered as the input port for that step.
//   Output channel out_valid_o / out_stall_i / out_item_o: exactly one
//   result item per input item, in order.
// Timing
//   A load item is written into the store at its accept edge; its result is
//   registered from PH_LOAD once the output is free. A step item reads the instruction byte at
//   its accept edge and the operand byte on the next edge, then executes
//   and registers its result once the output is free.
//   The single store port means two reads per instruction, one per byte.
//   The next item is taken at the same edge at which a result is registered;
//   a step taken there fetches from the forwarded new instruction pointer.
// Reset
//   Control and state registers clear; the store reads as HLT at address zero and zero
//   elsewhere through per-entry valid bits, so no clearing pass is needed.
// Stall
//   While out_stall_i holds a result, the finished item waits in its stage
//   and in_stall_o rises; nothing is lost or repeated.
module accumulator_cpu_step_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  acs_pkg::in_item_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output acs_pkg::out_item_t out_item_o
);

  // item phase: one-hot
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_FETCH = 4'b0010,  // instruction byte arriving, operand read issued
    PH_EXEC  = 4'b0100,  // operand byte arriving, execute
    PH_LOAD  = 4'b1000   // load written, result pending
  } phase_e;

  phase_e ph_q, ph_d;

  acs_pkg::in_item_t  item_q;
  acs_pkg::out_item_t out_q, res;
  logic               out_vq;

  logic [7:0] acc_q, acc_d, bak_q, bak_d, pc_q, pc_d;
  logic       halt_q, halt_d, fault_q, fault_d;
  logic [7:0] b0_q;

  acs_pkg::st_req_t st_req;
  logic [7:0]       st_rdata;

  logic accept, out_free, finish, exec_fire;

  acs_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (st_req),
    .rdata_o (st_rdata)
  );

  assign out_free   = !out_vq || !out_stall_i;
  assign finish     = ((ph_q == PH_EXEC) || (ph_q == PH_LOAD)) && out_free;
  assign exec_fire  = (ph_q == PH_EXEC) && out_free;
  assign in_stall_o = !((ph_q == PH_IDLE) || finish);
  assign accept     = in_valid_i && !in_stall_o;

  // ---------------- execute ----------------
  logic [7:0]     imm;
  logic [3:0]     hi;
  acs_pkg::insn_e lo;
  acs_pkg::kind_e src_k, dst_k;
  logic [7:0]     v, np, acc_n, bak_n, emit_val, dst_w;
  logic           bad, need_port, halt, emit, take, neg;

  assign imm = st_rdata;
  assign hi  = b0_q[7:4];
  assign lo  = acs_pkg::insn_e'(b0_q[3:0]);
  assign neg = acc_q[7];

  always_comb begin
    src_k = acs_pkg::K_NIL;
    if ((lo == acs_pkg::I_ADD) || (lo == acs_pkg::I_SUB) || (lo == acs_pkg::I_JRO)) begin
      src_k = acs_pkg::reg_kind({4'h0, hi});
    end else if (lo == acs_pkg::I_MOVR) begin
      src_k = acs_pkg::reg_kind(imm);
    end
    dst_k     = acs_pkg::reg_kind({4'h0, hi});
    bad       = (src_k == acs_pkg::K_BAD);
    need_port = (src_k == acs_pkg::K_PORT);
    case (src_k)
      acs_pkg::K_ACC:  v = acc_q;
      acs_pkg::K_PORT: v = item_q.port_byte;
      default:         v = 8'h00;
    endcase

    acc_n    = acc_q;
    bak_n    = bak_q;
    np       = pc_q + (b0_q[3] ? 8'd2 : 8'd1);
    halt     = 1'b0;
    emit     = 1'b0;
    emit_val = 8'h00;
    take     = 1'b0;
    dst_w    = (lo == acs_pkg::I_MOVI) ? imm : v;

    case (lo)
      acs_pkg::I_NOP: ;
      acs_pkg::I_SWP: begin
        acc_n = bak_q;
        bak_n = acc_q;
      end
      acs_pkg::I_SAV:  bak_n = acc_q;
      acs_pkg::I_ADD:  acc_n = acc_q + v;
      acs_pkg::I_SUB:  acc_n = acc_q - v;
      acs_pkg::I_NEG:  acc_n = 8'd0 - acc_q;
      acs_pkg::I_JRO:  np = np + v;
      acs_pkg::I_HLT:  halt = 1'b1;
      acs_pkg::I_MOVR, acs_pkg::I_MOVI: begin
        case (dst_k)
          acs_pkg::K_BAD:  bad = 1'b1;
          acs_pkg::K_ACC:  acc_n = dst_w;
          acs_pkg::K_PORT: begin
            emit     = 1'b1;
            emit_val = dst_w;
          end
          default: ;
        endcase
      end
      acs_pkg::I_ADDI: acc_n = acc_q + imm;
      acs_pkg::I_SUBI: acc_n = acc_q - imm;
      acs_pkg::I_JCC: begin
        case (hi)
          acs_pkg::JC_JMP: take = 1'b1;
          acs_pkg::JC_JEZ: take = (acc_q == 8'h00);
          acs_pkg::JC_JNZ: take = (acc_q != 8'h00);
          acs_pkg::JC_JGZ: take = (acc_q != 8'h00) && !neg;
          acs_pkg::JC_JLZ: take = neg;
          default:         bad  = 1'b1;
        endcase
        if (take) np = imm;
      end
      acs_pkg::I_JROI: np = np + imm;
      default:         bad = 1'b1;
    endcase
  end

  // commit and result
  always_comb begin
    acc_d   = acc_q;
    bak_d   = bak_q;
    pc_d    = pc_q;
    halt_d  = halt_q;
    fault_d = fault_q;
    res.status        = acs_pkg::ST_LOADED;
    res.port_consumed = 1'b0;
    res.out_valid     = 1'b0;
    res.out_byte      = 8'h00;

    if (ph_q == PH_EXEC) begin
      if (fault_q) begin
        res.status = acs_pkg::ST_FAULTED;
      end else if (halt_q) begin
        res.status = acs_pkg::ST_HALTED;
      end else if (bad) begin
        res.status = acs_pkg::ST_FAULTED;
        if (exec_fire) fault_d = 1'b1;
      end else if (need_port && !item_q.port_byte_valid) begin
        res.status = acs_pkg::ST_WAIT;
      end else begin
        res.status        = halt ? acs_pkg::ST_HALTED : acs_pkg::ST_EXECUTED;
        res.port_consumed = need_port;
        res.out_valid     = emit;
        res.out_byte      = emit_val;
        if (exec_fire) begin
          acc_d  = acc_n;
          bak_d  = bak_n;
          pc_d   = np;
          halt_d = halt;
        end
      end
    end
    res.accumulator = acc_d;
    res.next_pc     = pc_d;
  end

  // ---------------- store port ----------------
  always_comb begin
    st_req.en    = 1'b0;
    st_req.we    = 1'b0;
    st_req.addr  = acs_pkg::prog_index(pc_d);
    st_req.wdata = in_item_i.load_byte;
    if (accept) begin
      st_req.en = 1'b1;
      if (in_item_i.opcode == acs_pkg::OP_LOAD) begin
        st_req.we   = 1'b1;
        st_req.addr = acs_pkg::prog_index(in_item_i.load_address);
      end
    end else if (ph_q == PH_FETCH) begin
      st_req.en   = 1'b1;
      st_req.addr = acs_pkg::prog_index(pc_q + 8'd1);
    end
  end

  // ---------------- phase ----------------
  always_comb begin
    ph_d = ph_q;
    if (accept) begin
      ph_d = (in_item_i.opcode == acs_pkg::OP_STEP) ? PH_FETCH : PH_LOAD;
    end else if (finish) begin
      ph_d = PH_IDLE;
    end else if (ph_q == PH_FETCH) begin
      ph_d = PH_EXEC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_IDLE;
      out_vq  <= 1'b0;
      acc_q   <= 8'h00;
      bak_q   <= 8'h00;
      pc_q    <= 8'h00;
      halt_q  <= 1'b0;
      fault_q <= 1'b0;
    end else begin
      ph_q    <= ph_d;
      acc_q   <= acc_d;
      bak_q   <= bak_d;
      pc_q    <= pc_d;
      halt_q  <= halt_d;
      fault_q <= fault_d;
      if (finish) begin
        out_vq <= 1'b1;
      end else if (!out_stall_i) begin
        out_vq <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_item_i;
    if (ph_q == PH_FETCH) b0_q <= st_rdata;
    if (finish) out_q <= res;
  end

  assign out_valid_o = out_vq;
  assign out_item_o  = out_q;

  // ---------------- assertions ----------------
  a_no_accept_in_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_FETCH) |-> in_stall_o)
    else $error("item accepted while operand read pending");

  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q |=> fault_q)
    else $error("fault flag cleared");

  a_faulted_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fault_q || halt_q) |=> $stable(acc_q) && $stable(bak_q) && $stable(pc_q))
    else $error("architectural state changed while halted or faulted");

  a_fault_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fault_q) |-> $past(exec_fire))
    else $error("fault raised outside an executing step");

  a_result_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_vq)
    else $error("finished item produced no result");

endmodule
